FILE: hw/rtl/eebr_pkg.sv
package eebr_pkg;

  localparam int STORE_BYTES = 1024;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int LEN_W       = ADDR_W + 1;

  localparam int DIV_SH    = LEN_W + 4;
  localparam int DIV_RECIP = (2 ** DIV_SH + 8) / 9;
  localparam int GEOM_LAT  = 3;

  localparam logic [15:0] RST_ENDURANCE = 16'd1000;
  localparam logic [10:0] RST_LENGTH    = 11'd1024;
  localparam logic [9:0]  RST_START     = 10'd0;

  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_UPDATE = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_RESCAN = 3'd4;
  localparam logic [2:0] REQ_LOAD   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_DEPLETED = 2'd2;

  localparam logic [1:0] CFG_START  = 2'd0;
  localparam logic [1:0] CFG_LENGTH = 2'd1;
  localparam logic [1:0] CFG_ENDUR  = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  address;
    logic [7:0]  wdata;
    logic [15:0] endurance_value;
  } req_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [1:0]  status;
    logic [10:0] usable_length;
    logic [10:0] allocated_length;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] first;
    logic [LEN_W-1:0]  total;
    logic [LEN_W-1:0]  dl;
    logic [LEN_W-1:0]  base;
  } geom_t;

endpackage

FILE: hw/rtl/eeprom_bad_byte_remapper_unit.sv
// Wear-limited byte store with a bad-byte bitmap. Every request is handled
// alone by a sequencer around one read port per store; one result comes back
// per request. Each virtual address lookup walks the control bitmap one data
// byte per cycle, pausing to fetch each control byte. Read takes one lookup;
// write and update take one unless relocation is needed, rescan reads each
// control byte in turn, and a full clear writes the region a byte at a time.
// A write that keeps failing relocates data: each shifted byte costs two
// lookups, so that case grows with allocated length times region size.
// After reset the block clears all 1024 store entries, one per cycle, and
// accepts no request meanwhile; writing region start or length triggers a
// rescan before the block is ready again.
module eeprom_bad_byte_remapper_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  eebr_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output eebr_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import eebr_pkg::*;

  typedef enum logic [4:0] {
    S_RST, S_IDLE, S_SETTLE, S_RS, S_RSB, S_LK, S_LKB, S_WAIT, S_RDD,
    S_UCHK, S_WCHK, S_WTRY, S_RL0, S_DB1, S_DB2, S_RLL, S_CP, S_CPX,
    S_CPY, S_CLR, S_FIN
  } state_t;

  state_t state, lret, wret;

  req_t              q;
  logic [9:0]        region_start;
  logic [10:0]       region_length;
  logic [15:0]       def_end;
  geom_t             g;
  logic [LEN_W-1:0]  p, wv, uc, nbits, cnt;
  logic [ADDR_W-1:0] ma, phys, d, hw, wa;
  logic [2:0]        bitpos;
  logic [7:0]        xval, rdata_r, ws;
  logic [1:0]        status_r;
  logic [15:0]       ww;
  logic              we;
  logic              wo;
  logic [7:0]        s_rd;
  logic [15:0]       w_rd;

  logic              lk_bit, lk_last, lk_done, hw_ok, upd;
  logic [LEN_W-1:0]  rs_rem, nbits_n;
  logic [7:0]        rs_mask, newc, newv, vd;
  logic [3:0]        rs_cnt;
  logic [ADDR_W-1:0] db, dm1, hw_max;

  eebr_geom u_geom (
    .clk           (clk),
    .region_start  (region_start),
    .region_length (region_length),
    .geom          (g)
  );

  eebr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (we && !wo),
    .waddr (wa),
    .wdata (ws),
    .raddr (ma),
    .rdata (s_rd)
  );

  eebr_ram #(.WIDTH(16), .DEPTH(STORE_BYTES)) u_wear (
    .clk   (clk),
    .we    (we),
    .waddr (wa),
    .wdata (ww),
    .raddr (ma),
    .rdata (w_rd)
  );

  always_comb begin
    lk_bit  = s_rd[p[2:0]];
    lk_last = (p == g.dl - LEN_W'(1));
    lk_done = lk_bit ? lk_last : (wv == '0 || lk_last);
    hw_ok   = (LEN_W'(hw) + LEN_W'(1)) < uc;
    rs_rem  = g.dl - p;
    rs_mask = (rs_rem >= LEN_W'(8)) ? 8'hFF : ((8'h1 << rs_rem[2:0]) - 8'h1);
    rs_cnt  = 4'($countones(s_rd & rs_mask));
    nbits_n = nbits + LEN_W'(rs_cnt);
    db      = phys - g.first;
    newc    = s_rd | (8'h1 << bitpos);
    dm1     = d - ADDR_W'(1);
    upd     = (s_rd != xval) && (w_rd != '0);
    newv    = upd ? xval : s_rd;
    vd      = (LEN_W'(d) < uc) ? newv : 8'h0;
    hw_max  = (ADDR_W'(q.address) > hw) ? ADDR_W'(q.address) : hw;
  end

  assign req_ready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_RST;
      lret          <= S_IDLE;
      wret          <= S_IDLE;
      cnt           <= '0;
      hw            <= '0;
      uc            <= '0;
      we            <= 1'b0;
      wo            <= 1'b0;
      rsp_valid     <= 1'b0;
      region_start  <= RST_START;
      region_length <= RST_LENGTH;
      def_end       <= RST_ENDURANCE;
    end else begin
      we <= 1'b0;
      wo <= 1'b0;
      if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_RST: begin
          if (cnt == LEN_W'(STORE_BYTES)) begin
            uc    <= g.dl;
            state <= S_IDLE;
          end else begin
            we  <= 1'b1;
            wa  <= ADDR_W'(cnt);
            ws  <= 8'h0;
            ww  <= RST_ENDURANCE;
            cnt <= cnt + LEN_W'(1);
          end
        end
        S_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              CFG_START: begin
                region_start <= cfg_data[9:0];
                cnt          <= '0;
                lret         <= S_IDLE;
                state        <= S_SETTLE;
              end
              CFG_LENGTH: begin
                region_length <= cfg_data[10:0];
                cnt           <= '0;
                lret          <= S_IDLE;
                state         <= S_SETTLE;
              end
              CFG_ENDUR: def_end <= cfg_data;
              default: ;
            endcase
          end else if (req_valid) begin
            q        <= req;
            rdata_r  <= 8'h0;
            status_r <= ST_OK;
            case (req.req_type)
              REQ_READ, REQ_WRITE, REQ_UPDATE: begin
                if (LEN_W'(req.address) >= uc) begin
                  status_r <= ST_RANGE;
                  state    <= S_FIN;
                end else begin
                  wv    <= LEN_W'(req.address);
                  state <= S_LK;
                  if (req.req_type == REQ_READ) begin
                    lret <= S_RDD;
                  end else if (req.req_type == REQ_UPDATE) begin
                    lret <= S_UCHK;
                  end else begin
                    lret <= S_WCHK;
                    if (ADDR_W'(req.address) > hw) begin
                      hw <= ADDR_W'(req.address);
                    end
                  end
                end
              end
              REQ_CLEAR: begin
                cnt   <= '0;
                state <= S_CLR;
              end
              REQ_RESCAN: begin
                lret  <= S_FIN;
                state <= S_RS;
              end
              REQ_LOAD: begin
                if (LEN_W'(req.address) < LEN_W'(STORE_BYTES)) begin
                  we <= 1'b1;
                  wo <= 1'b1;
                  wa <= ADDR_W'(req.address);
                  ws <= 8'h0;
                  ww <= req.endurance_value;
                end else begin
                  status_r <= ST_RANGE;
                end
                state <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_SETTLE: begin
          cnt <= cnt + LEN_W'(1);
          if (cnt == LEN_W'(GEOM_LAT - 1)) begin
            state <= S_RS;
          end
        end
        S_RS: begin
          p     <= '0;
          nbits <= '0;
          if (g.dl == '0) begin
            uc    <= '0;
            state <= lret;
          end else begin
            ma    <= ADDR_W'(g.base);
            wret  <= S_RSB;
            state <= S_WAIT;
          end
        end
        S_RSB: begin
          if (p + LEN_W'(8) >= g.dl) begin
            uc    <= g.dl - nbits_n;
            state <= lret;
          end else begin
            p     <= p + LEN_W'(8);
            nbits <= nbits_n;
            ma    <= ADDR_W'(g.base + ((p + LEN_W'(8)) >> 3));
            wret  <= S_RSB;
            state <= S_WAIT;
          end
        end
        S_LK: begin
          p <= '0;
          if (g.dl == '0) begin
            phys  <= g.first;
            ma    <= g.first;
            wret  <= lret;
            state <= S_WAIT;
          end else begin
            ma    <= ADDR_W'(g.base);
            wret  <= S_LKB;
            state <= S_WAIT;
          end
        end
        S_LKB: begin
          if (lk_done) begin
            phys  <= g.first + ADDR_W'(p);
            ma    <= g.first + ADDR_W'(p);
            wret  <= lret;
            state <= S_WAIT;
          end else begin
            if (!lk_bit) begin
              wv <= wv - LEN_W'(1);
            end
            p <= p + LEN_W'(1);
            if (p[2:0] == 3'd7) begin
              ma    <= ADDR_W'(g.base + ((p + LEN_W'(1)) >> 3));
              wret  <= S_LKB;
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: state <= wret;
        S_RDD: begin
          rdata_r <= s_rd;
          state   <= S_FIN;
        end
        S_UCHK: begin
          hw <= hw_max;
          if (s_rd != q.wdata) begin
            state <= S_WCHK;
          end else begin
            state <= S_FIN;
          end
        end
        S_WCHK: begin
          if (w_rd != '0) begin
            we    <= 1'b1;
            wa    <= phys;
            ws    <= q.wdata;
            ww    <= w_rd - 16'd1;
            state <= S_FIN;
          end else if (s_rd == q.wdata) begin
            state <= S_FIN;
          end else begin
            state <= S_RL0;
          end
        end
        S_WTRY: begin
          wv    <= LEN_W'(q.address);
          lret  <= S_WCHK;
          state <= S_LK;
        end
        S_RL0: begin
          if (!hw_ok) begin
            status_r <= ST_DEPLETED;
            state    <= S_FIN;
          end else begin
            wv    <= LEN_W'(q.address);
            lret  <= S_DB1;
            state <= S_LK;
          end
        end
        S_DB1: begin
          bitpos <= db[2:0];
          ma     <= ADDR_W'(g.base + LEN_W'(db >> 3));
          wret   <= S_DB2;
          state  <= S_WAIT;
        end
        S_DB2: begin
          if (newc != s_rd && w_rd != '0) begin
            we <= 1'b1;
            wa <= ma;
            ws <= newc;
            ww <= w_rd - 16'd1;
          end
          if (uc != '0) begin
            uc <= uc - LEN_W'(1);
          end
          state <= S_RLL;
        end
        S_RLL: begin
          if (hw <= ADDR_W'(q.address)) begin
            if (hw_ok) begin
              state <= S_WTRY;
            end else begin
              status_r <= ST_DEPLETED;
              state    <= S_FIN;
            end
          end else begin
            d     <= hw;
            state <= S_CP;
          end
        end
        S_CP: begin
          wv    <= LEN_W'(dm1);
          lret  <= S_CPX;
          state <= S_LK;
        end
        S_CPX: begin
          xval  <= (LEN_W'(dm1) < uc) ? s_rd : 8'h0;
          wv    <= LEN_W'(d);
          lret  <= S_CPY;
          state <= S_LK;
        end
        S_CPY: begin
          if (upd) begin
            we <= 1'b1;
            wa <= phys;
            ws <= xval;
            ww <= w_rd - 16'd1;
          end
          if (vd == xval) begin
            if (dm1 == ADDR_W'(q.address)) begin
              if (hw_ok) begin
                state <= S_WTRY;
              end else begin
                status_r <= ST_DEPLETED;
                state    <= S_FIN;
              end
            end else begin
              d     <= dm1;
              state <= S_CP;
            end
          end else if (hw_ok) begin
            wv    <= LEN_W'(d);
            lret  <= S_DB1;
            state <= S_LK;
          end else begin
            status_r <= ST_DEPLETED;
            state    <= S_FIN;
          end
        end
        S_CLR: begin
          if (cnt >= g.total) begin
            uc    <= g.dl;
            state <= S_FIN;
          end else begin
            we  <= 1'b1;
            wa  <= g.first + ADDR_W'(cnt);
            ws  <= 8'h0;
            ww  <= def_end;
            cnt <= cnt + LEN_W'(1);
          end
        end
        S_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.rdata            <= rdata_r;
            rsp.status           <= status_r;
            rsp.usable_length    <= 11'(uc);
            rsp.allocated_length <= 11'(LEN_W'(hw) + LEN_W'(1));
            rsp_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/eebr_ram.sv
module eebr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/eebr_geom.sv
module eebr_geom (
  input  logic          clk,
  input  logic [9:0]    region_start,
  input  logic [10:0]   region_length,
  output eebr_pkg::geom_t geom
);
  import eebr_pkg::*;

  localparam int PROD_W = LEN_W + 1 + DIV_SH;

  logic [LEN_W-1:0]  first_c;
  logic [LEN_W-1:0]  room_c;
  logic [LEN_W-1:0]  total_c;
  logic [ADDR_W-1:0] first_a;
  logic [LEN_W-1:0]  total_a;
  logic [ADDR_W-1:0] first_b;
  logic [LEN_W-1:0]  total_b;
  logic [LEN_W-1:0]  ctl_b;
  logic [PROD_W-1:0] prod;

  always_comb begin
    first_c = (LEN_W'(region_start) < LEN_W'(STORE_BYTES - 1)) ?
              LEN_W'(region_start) : LEN_W'(STORE_BYTES - 1);
    room_c  = LEN_W'(STORE_BYTES) - first_c;
    total_c = (LEN_W'(region_length) < room_c) ? LEN_W'(region_length) : room_c;
    prod    = (PROD_W'(total_a) + PROD_W'(8)) * PROD_W'(DIV_RECIP);
  end

  always_ff @(posedge clk) begin
    first_a    <= ADDR_W'(first_c);
    total_a    <= total_c;
    first_b    <= first_a;
    total_b    <= total_a;
    ctl_b      <= LEN_W'(prod >> DIV_SH);
    geom.first <= first_b;
    geom.total <= total_b;
    geom.dl    <= total_b - ctl_b;
    geom.base  <= LEN_W'(first_b) + total_b - ctl_b;
  end

endmodule

FILE: hw/rtl/eebr_checker.sv
module eebr_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input eebr_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input eebr_pkg::rsp_t rsp
);
  import eebr_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in progress");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_RANGE ||
                  rsp.status == ST_DEPLETED)
    else $error("undefined status code");

  a_lengths: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.allocated_length != 11'd0 &&
                  rsp.usable_length <= 11'(STORE_BYTES))
    else $error("length out of bounds");

endmodule

bind eeprom_bad_byte_remapper_unit eebr_checker u_eebr_checker (.*);
